// ----- src/bmhq_pkg.sv -----
package bmhq_pkg;

  // requested operation, carried on the slave-side tuser
  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_POP  = 1'b1
  } op_e;

  // result status, carried on the master-side tuser
  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  // request from the stream front end to the heap engine
  typedef struct packed {
    logic start;
    op_e  op;
  } bmhq_req_t;

  // engine status back to the stream front end
  typedef struct packed {
    logic    idle;
    logic    done;
    status_e status;
  } bmhq_rsp_t;

endpackage

// ----- src/bmhq_cmp.sv -----
module bmhq_cmp #(
  parameter int KEY_WIDTH = 32
) (
  input  logic [KEY_WIDTH-1:0] a_i,
  input  logic [KEY_WIDTH-1:0] b_i,
  output logic                 less_o,
  output logic [KEY_WIDTH-1:0] max_o
);

  // signed compare, ties keep the first operand
  assign less_o = $signed(a_i) < $signed(b_i);
  assign max_o  = less_o ? b_i : a_i;

endmodule

// ----- src/bmhq_engine.sv -----
module bmhq_engine #(
  parameter int CAPACITY  = 1024,
  parameter int KEY_WIDTH = 32,
  parameter int AW        = $clog2(CAPACITY),
  parameter int CW        = $clog2(CAPACITY + 1)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  bmhq_pkg::bmhq_req_t  req_i,
  input  logic [KEY_WIDTH-1:0] key_i,
  input  logic                 ack_i,
  output bmhq_pkg::bmhq_rsp_t  rsp_o,
  output logic [KEY_WIDTH-1:0] key_o,
  output logic [CW-1:0]        fill_o
);

  localparam int LW = AW + 1;
  localparam logic [CW-1:0] CapC = CW'(CAPACITY);

  typedef enum logic [3:0] {
    S_IDLE,
    S_UP_RD,
    S_UP_CMP,
    S_DN_ROOT,
    S_DN_LAST,
    S_DN_KEY,
    S_DN_RDL,
    S_DN_LEFT,
    S_DN_RIGHT,
    S_DONE
  } state_e;

  state_e                 state_q, state_d;
  logic [AW-1:0]          idx_q, idx_d;
  logic [KEY_WIDTH-1:0]   key_q, key_d;
  logic [KEY_WIDTH-1:0]   best_q, best_d;
  logic                   lsel_q, lsel_d;
  logic [CW-1:0]          cnt_q, cnt_d;
  logic [KEY_WIDTH-1:0]   kout_q, kout_d;
  bmhq_pkg::status_e      status_q, status_d;

  // heap storage
  logic [KEY_WIDTH-1:0]   mem [CAPACITY];
  logic [KEY_WIDTH-1:0]   rd_data_q;
  logic                   mem_we;
  logic [AW-1:0]          mem_wa;
  logic [KEY_WIDTH-1:0]   mem_wd;
  logic [AW-1:0]          mem_ra;

  // shared compare unit
  logic [KEY_WIDTH-1:0]   cmp_a, cmp_b, cmp_max;
  logic                   cmp_less;

  // tree index arithmetic
  logic [AW-1:0]          parent;
  logic [LW-1:0]          left, right, n_ext;

  assign parent = (idx_q - AW'(1)) >> 1;
  assign left   = {idx_q, 1'b1};
  assign right  = {idx_q, 1'b0} + LW'(2);
  assign n_ext  = LW'(cnt_q);

  bmhq_cmp #(
    .KEY_WIDTH(KEY_WIDTH)
  ) u_cmp (
    .a_i   (cmp_a),
    .b_i   (cmp_b),
    .less_o(cmp_less),
    .max_o (cmp_max)
  );

  // memory with registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_data_q <= mem[mem_ra];
  end

  // sequencer next state
  always_comb begin
    state_d  = state_q;
    idx_d    = idx_q;
    key_d    = key_q;
    best_d   = best_q;
    lsel_d   = lsel_q;
    cnt_d    = cnt_q;
    kout_d   = kout_q;
    status_d = status_q;
    mem_we   = 1'b0;
    mem_wa   = idx_q;
    mem_wd   = key_q;
    mem_ra   = '0;
    cmp_a    = key_q;
    cmp_b    = rd_data_q;
    case (state_q)
      S_IDLE: begin
        if (req_i.start) begin
          kout_d   = '0;
          status_d = bmhq_pkg::ST_DONE;
          if (req_i.op == bmhq_pkg::OP_PUSH) begin
            if (cnt_q == CapC) begin
              status_d = bmhq_pkg::ST_FULL;
              state_d  = S_DONE;
            end else begin
              idx_d   = cnt_q[AW-1:0];
              key_d   = key_i;
              cnt_d   = cnt_q + CW'(1);
              state_d = S_UP_RD;
            end
          end else begin
            if (cnt_q == '0) begin
              status_d = bmhq_pkg::ST_EMPTY;
              state_d  = S_DONE;
            end else begin
              cnt_d   = cnt_q - CW'(1);
              state_d = S_DN_ROOT;
            end
          end
        end
      end
      // sift up: fetch parent, or settle at the root
      S_UP_RD: begin
        if (idx_q == '0) begin
          mem_we  = 1'b1;
          state_d = S_DONE;
        end else begin
          mem_ra  = parent;
          state_d = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        cmp_a = rd_data_q;
        cmp_b = key_q;
        mem_we = 1'b1;
        if (cmp_less) begin
          mem_wd  = rd_data_q;
          idx_d   = parent;
          state_d = S_UP_RD;
        end else begin
          state_d = S_DONE;
        end
      end
      // pop: read root, then last element
      S_DN_ROOT: begin
        mem_ra  = '0;
        state_d = S_DN_LAST;
      end
      S_DN_LAST: begin
        kout_d = rd_data_q;
        if (cnt_q == '0) begin
          state_d = S_DONE;
        end else begin
          mem_ra  = cnt_q[AW-1:0];
          state_d = S_DN_KEY;
        end
      end
      S_DN_KEY: begin
        key_d   = rd_data_q;
        idx_d   = '0;
        state_d = S_DN_RDL;
      end
      // sift down: fetch left child or settle
      S_DN_RDL: begin
        if (left >= n_ext) begin
          mem_we  = 1'b1;
          state_d = S_DONE;
        end else begin
          mem_ra  = left[AW-1:0];
          state_d = S_DN_LEFT;
        end
      end
      S_DN_LEFT: begin
        best_d = cmp_max;
        lsel_d = cmp_less;
        if (right < n_ext) begin
          mem_ra  = right[AW-1:0];
          state_d = S_DN_RIGHT;
        end else begin
          mem_we = 1'b1;
          if (cmp_less) begin
            mem_wd  = rd_data_q;
            idx_d   = left[AW-1:0];
            state_d = S_DN_RDL;
          end else begin
            state_d = S_DONE;
          end
        end
      end
      S_DN_RIGHT: begin
        cmp_a  = best_q;
        mem_we = 1'b1;
        if (cmp_less) begin
          mem_wd  = rd_data_q;
          idx_d   = right[AW-1:0];
          state_d = S_DN_RDL;
        end else if (lsel_q) begin
          mem_wd  = best_q;
          idx_d   = left[AW-1:0];
          state_d = S_DN_RDL;
        end else begin
          state_d = S_DONE;
        end
      end
      // hold the result until the output stage takes it
      S_DONE: begin
        if (ack_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // sequencer registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      idx_q    <= '0;
      key_q    <= '0;
      best_q   <= '0;
      cnt_q    <= '0;
      kout_q   <= '0;
      status_q <= bmhq_pkg::ST_DONE;
      lsel_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      idx_q    <= idx_d;
      key_q    <= key_d;
      best_q   <= best_d;
      cnt_q    <= cnt_d;
      kout_q   <= kout_d;
      status_q <= status_d;
      lsel_q   <= lsel_d;
    end
  end

  assign rsp_o.idle   = (state_q == S_IDLE);
  assign rsp_o.done   = (state_q == S_DONE);
  assign rsp_o.status = status_q;
  assign key_o        = kout_q;
  assign fill_o       = cnt_q;

endmodule

// ----- src/binary_max_heap_queue.sv -----
// push: one read of the heap memory and one compare per level climbed, up to log2(CAPACITY) levels
// pop: each level descended takes one or two reads of the heap memory (one read port,
// one write port) and one pass through the shared compare unit per read
// one transaction in flight, next accept in the cycle after the result is loaded
// full and empty cases go straight to the result; reset clears the count and control,
// heap memory is not cleared and needs no pass
module binary_max_heap_queue #(
  parameter int CAPACITY  = 1024,
  parameter int KEY_WIDTH = 32
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  // key_in
  input  logic [((KEY_WIDTH+7)/8)*8-1:0]         s_axis_tdata,
  // op
  input  logic                                   s_axis_tuser,
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  // key_out, fill_level
  output logic [((KEY_WIDTH+$clog2(CAPACITY+1)+7)/8)*8-1:0] m_axis_tdata,
  // status
  output logic [1:0]                             m_axis_tuser
);

  localparam int AW     = $clog2(CAPACITY);
  localparam int CW     = $clog2(CAPACITY + 1);
  localparam int OUT_TW = ((KEY_WIDTH + CW + 7) / 8) * 8;

  bmhq_pkg::bmhq_req_t  req;
  bmhq_pkg::bmhq_rsp_t  rsp;
  logic [KEY_WIDTH-1:0] eng_key;
  logic [CW-1:0]        eng_fill;
  logic                 load;

  logic                 out_valid_q, out_valid_d;
  logic [KEY_WIDTH-1:0] out_key_q;
  logic [CW-1:0]        out_fill_q;
  bmhq_pkg::status_e    out_status_q;

  // input transaction starts the engine
  assign s_axis_tready = rsp.idle;
  assign req.start     = s_axis_tvalid & rsp.idle;
  assign req.op        = bmhq_pkg::op_e'(s_axis_tuser);

  bmhq_engine #(
    .CAPACITY (CAPACITY),
    .KEY_WIDTH(KEY_WIDTH),
    .AW       (AW),
    .CW       (CW)
  ) u_engine (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req),
    .key_i (s_axis_tdata[KEY_WIDTH-1:0]),
    .ack_i (load),
    .rsp_o (rsp),
    .key_o (eng_key),
    .fill_o(eng_fill)
  );

  // output register, frees the engine while a result waits
  assign load        = rsp.done & (~out_valid_q | m_axis_tready);
  assign out_valid_d = load | (out_valid_q & ~m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_key_q    <= eng_key;
      out_fill_q   <= eng_fill;
      out_status_q <= rsp.status;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_TW'({out_fill_q, out_key_q});
  assign m_axis_tuser  = out_status_q;

endmodule

// ----- tb/sv/tb_binary_max_heap_queue.sv -----
module tb_binary_max_heap_queue;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CAPACITY  = 1024;
  localparam int KW        = 32;
  localparam int FW        = $clog2(CAPACITY + 1);
  localparam int IN_W      = ((KW + 7) / 8) * 8;
  localparam int OUT_W     = ((KW + FW + 7) / 8) * 8;
  localparam int STALL_MAX = 5000;
  localparam int HOLD_LEN  = 300;
  localparam logic signed [KW-1:0] KEY_MAX = 32'sh7fffffff;
  localparam logic signed [KW-1:0] KEY_MIN = 32'sh80000000;

  // one queue operation as offered on the slave side
  typedef struct {
    bmhq_pkg::op_e         op;
    logic signed [KW-1:0]  key;
    bit                    drain_first;
  } heap_req_t;

  // one expected reply of the queue
  typedef struct {
    logic signed [KW-1:0]  key_out;
    bmhq_pkg::status_e     status;
    logic [FW-1:0]         fill;
  } heap_reply_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [IN_W-1:0]   s_axis_tdata = '0;   // key_in
  logic              s_axis_tuser = 1'b0; // op
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [OUT_W-1:0]  m_axis_tdata;        // key_out, fill_level
  logic [1:0]        m_axis_tuser;        // status

  // shadow heap, updated at each accepted operation
  logic signed [KW-1:0] heap_mem [CAPACITY];
  int                   heap_cnt = 0;

  heap_req_t   op_q[$];
  heap_reply_t reply_q[$];

  int  gen_fill = 0;
  bit  drain_next = 1'b0;
  bit  offering = 1'b0;
  int  in_cnt = 0;
  int  out_cnt = 0;
  int  err_cnt = 0;
  int  stall_cycles = 0;
  int  hold_left = 0;
  bit  hold_a_done = 1'b0;
  bit  hold_b_done = 1'b0;
  bit  in_quiet;
  bit  out_quiet;

  binary_max_heap_queue #(
    .CAPACITY  (CAPACITY),
    .KEY_WIDTH (KW)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // apply one operation to the shadow heap and return the reply it yields
  function automatic void shadow_heap_op(input bmhq_pkg::op_e op,
                                         input logic signed [KW-1:0] key,
                                         output heap_reply_t r);
    int idx;
    int par;
    int lft;
    int rgt;
    int big;
    logic signed [KW-1:0] tmp;
    r.key_out = '0;
    r.status  = bmhq_pkg::ST_DONE;
    if (op == bmhq_pkg::OP_PUSH) begin
      if (heap_cnt >= CAPACITY) begin
        r.status = bmhq_pkg::ST_FULL;
      end else begin
        idx = heap_cnt;
        heap_mem[idx] = key;
        // sift up past strictly smaller parents
        while (idx > 0) begin
          par = (idx - 1) / 2;
          if (heap_mem[par] >= heap_mem[idx]) break;
          tmp = heap_mem[par];
          heap_mem[par] = heap_mem[idx];
          heap_mem[idx] = tmp;
          idx = par;
        end
        heap_cnt++;
      end
    end else begin
      if (heap_cnt == 0) begin
        r.status = bmhq_pkg::ST_EMPTY;
      end else begin
        r.key_out = heap_mem[0];
        heap_cnt--;
        heap_mem[0] = heap_mem[heap_cnt];
        idx = 0;
        // sift down toward the larger child, left wins a tie
        while (1) begin
          lft = 2 * idx + 1;
          rgt = lft + 1;
          big = idx;
          if (lft >= heap_cnt) break;
          if (heap_mem[big] < heap_mem[lft]) big = lft;
          if (rgt < heap_cnt && heap_mem[big] < heap_mem[rgt]) big = rgt;
          if (big == idx) break;
          tmp = heap_mem[big];
          heap_mem[big] = heap_mem[idx];
          heap_mem[idx] = tmp;
          idx = big;
        end
      end
    end
    r.fill = heap_cnt[FW-1:0];
  endfunction

  task automatic report_mismatch(input string field, input longint got, input longint want);
    $display("[%0t] mismatch on %s at result %0d: got %0d, want %0d",
             $time, field, out_cnt, got, want);
    err_cnt++;
  endtask

  // key mix: full range, a narrow band for ties, and the extremes
  function automatic logic signed [KW-1:0] pick_key();
    int k;
    case ($urandom_range(0, 9))
      6, 7: begin
        k = $urandom_range(0, 15);
        return k - 8;
      end
      8: begin
        case ($urandom_range(0, 3))
          0: return KEY_MAX;
          1: return KEY_MIN;
          2: return '0;
          default: return -1;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  task automatic add_item(input bmhq_pkg::op_e op, input logic signed [KW-1:0] key);
    heap_req_t it;
    it.op = op;
    it.key = key;
    it.drain_first = drain_next;
    drain_next = 1'b0;
    op_q.push_back(it);
    if (op == bmhq_pkg::OP_PUSH) begin
      if (gen_fill < CAPACITY) gen_fill++;
    end else if (gen_fill > 0) begin
      gen_fill--;
    end
  endtask

  task automatic run_mix(input int count, input int push_pct);
    repeat (count) begin
      if ($urandom_range(0, 99) < push_pct) add_item(bmhq_pkg::OP_PUSH, pick_key());
      else add_item(bmhq_pkg::OP_POP, $urandom);
    end
  endtask

  // slave-side transaction accept and prediction
  always @(posedge clk_i) begin
    heap_req_t   cur;
    heap_reply_t r;
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      cur = op_q.pop_front();
      shadow_heap_op(cur.op, cur.key, r);
      reply_q.push_back(r);
      offering = 1'b0;
      in_cnt++;
    end
  end

  // slave-side driver
  always @(negedge clk_i) begin
    in_quiet = (in_cnt >= 700 && in_cnt < 1000);
    if (rst_ni && !offering) begin
      if (op_q.size() > 0 && !(op_q[0].drain_first && reply_q.size() > 0) &&
          (in_quiet || $urandom_range(0, 99) >= 34)) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= op_q[0].key;
        s_axis_tuser  <= op_q[0].op;
        offering = 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // master-side ready, with random gaps and two long holds
  always @(negedge clk_i) begin
    out_quiet = (out_cnt >= 700 && out_cnt < 1000);
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if ((!hold_a_done && out_cnt >= 400) || (!hold_b_done && out_cnt >= 1500)) begin
      if (out_cnt >= 1500) hold_b_done = 1'b1;
      hold_a_done = 1'b1;
      hold_left = HOLD_LEN;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= out_quiet || ($urandom_range(0, 99) >= 34);
    end
  end

  // master-side transaction check
  always @(posedge clk_i) begin
    heap_reply_t          want;
    logic signed [KW-1:0] got_key;
    logic [FW-1:0]        got_fill;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got_key  = $signed(m_axis_tdata[KW-1:0]);
      got_fill = m_axis_tdata[KW+FW-1:KW];
      if (reply_q.size() == 0) begin
        report_mismatch("unrequested result", got_key, 0);
      end else begin
        want = reply_q.pop_front();
        if (got_key !== want.key_out) report_mismatch("key_out", got_key, want.key_out);
        if (m_axis_tuser !== want.status) report_mismatch("status", m_axis_tuser, want.status);
        if (got_fill !== want.fill) report_mismatch("fill_level", got_fill, want.fill);
      end
      out_cnt++;
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      stall_cycles = 0;
    else
      stall_cycles++;
    if (stall_cycles >= STALL_MAX) begin
      $display("timeout: no transaction for %0d cycles", STALL_MAX);
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    // directed: empty pop, extremes, bit patterns, equal keys, drain past empty
    add_item(bmhq_pkg::OP_POP, $urandom);
    add_item(bmhq_pkg::OP_PUSH, KEY_MAX);
    add_item(bmhq_pkg::OP_PUSH, KEY_MIN);
    add_item(bmhq_pkg::OP_PUSH, '0);
    add_item(bmhq_pkg::OP_PUSH, -1);
    add_item(bmhq_pkg::OP_PUSH, 1);
    add_item(bmhq_pkg::OP_PUSH, 32'shaaaaaaaa);
    add_item(bmhq_pkg::OP_PUSH, 32'sh55555555);
    add_item(bmhq_pkg::OP_PUSH, 5);
    add_item(bmhq_pkg::OP_PUSH, 5);
    add_item(bmhq_pkg::OP_PUSH, 5);
    repeat (11) add_item(bmhq_pkg::OP_POP, $urandom);

    // random: mixed, fill to capacity, push on full, mixed, drain, mixed
    drain_next = 1'b1;
    run_mix(100, 50);
    while (gen_fill < CAPACITY) begin
      if ($urandom_range(0, 99) < 90) add_item(bmhq_pkg::OP_PUSH, pick_key());
      else add_item(bmhq_pkg::OP_POP, $urandom);
    end
    add_item(bmhq_pkg::OP_PUSH, KEY_MAX);
    run_mix(40, 75);
    drain_next = 1'b1;
    run_mix(300, 15);
    run_mix(100, 50);

    // reset
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (op_q.size() != 0 || reply_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (err_cnt == 0 && reply_q.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
